### src/link_delay_time_sync_trainer_defines.svh
// assertion helpers for the trainer rtl
`ifndef LINK_DELAY_TIME_SYNC_TRAINER_DEFINES_SVH
`define LINK_DELAY_TIME_SYNC_TRAINER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LDTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define LDTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/ldts_pkg.sv
package ldts_pkg;

  localparam int DATA_W = 32;
  localparam int CI_W   = 12;

  localparam logic [CI_W-1:0] CI_RESET = 12'd50;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_MSG  = 1'b1;

  typedef enum logic [1:0] {
    ST_NOT_STARTED = 2'd0,
    ST_PENDING     = 2'd1,
    ST_SUCCEEDED   = 2'd2,
    ST_FAILED      = 2'd3
  } status_t;

  typedef struct packed {
    logic              req_type;
    logic [DATA_W-1:0] now_time;
    logic [DATA_W-1:0] received_time;
    logic [DATA_W-1:0] reference_time;
  } in_t;

  typedef struct packed {
    status_t           train_status;
    logic [DATA_W-1:0] adjusted_time;
    logic              timed_out;
    logic              round_done;
  } out_t;

endpackage

### src/ldts_div.sv
module ldts_div
  import ldts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [CI_W-1:0]   divisor,
  output logic              done,
  output logic [DATA_W-1:0] quot,
  output logic [CI_W-1:0]   rem
);

  localparam int STEP_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] dvd_r;
  logic [CI_W-1:0]   rem_r;
  logic [CI_W-1:0]   dsr_r;

  logic [CI_W:0]     trial;
  logic [CI_W:0]     diff;
  logic              fits;
  logic [CI_W-1:0]   rem_nxt;
  logic [DATA_W-1:0] dvd_nxt;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial   = {rem_r, dvd_r[DATA_W-1]};
    diff    = trial - {1'b0, dsr_r};
    fits    = (trial >= {1'b0, dsr_r});
    rem_nxt = fits ? diff[CI_W-1:0] : trial[CI_W-1:0];
    dvd_nxt = {dvd_r[DATA_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        dvd_r  <= dividend;
        rem_r  <= '0;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        dvd_r  <= dvd_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dvd_r;
  assign rem  = rem_r;

endmodule

### src/ldts_mul.sv
module ldts_mul
  import ldts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] mcand,
  input  logic [CI_W-1:0]   mplier,
  output logic              done,
  output logic [DATA_W-1:0] prod
);

  localparam int STEP_W = $clog2(CI_W);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [DATA_W-1:0] a_r;
  logic [CI_W-1:0]   b_r;
  logic [DATA_W-1:0] acc_r;

  logic [DATA_W-1:0] acc_nxt;

  // shift-add, multiplier msb first, product kept modulo 2^32
  always_comb begin
    acc_nxt = {acc_r[DATA_W-2:0], 1'b0} + (b_r[CI_W-1] ? a_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        a_r    <= mcand;
        b_r    <= mplier;
        acc_r  <= '0;
      end else if (busy_r) begin
        acc_r  <= acc_nxt;
        b_r    <= {b_r[CI_W-2:0], 1'b0};
        step_r <= step_r + STEP_W'(1);
        if (step_r == STEP_W'(CI_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

### src/link_delay_time_sync_trainer.sv
// channel  | ports                                  | role
// ---------+----------------------------------------+----------------------------------
// in       | in_valid, in_ready, in_data            | tick or training message beat
// out      | out_valid, out_ready, out_data         | one status beat per input beat
// cfg      | cfg_wr_en, cfg_wr_data                 | connection interval, ms
//
// tick with no round pending goes straight to the output; round-opening message: no divider pass
// tick with a round pending, message with a pending pair: 32-step serial divider
// message closing a valid round: two divider passes and, unless the average is zero,
//   the 12-step shift-add multiplier
// synchronous reset, no clearing pass; a finished beat waits in the output register
//   and the next input beat is taken once the result is stored there
`include "link_delay_time_sync_trainer_defines.svh"

module link_delay_time_sync_trainer
  import ldts_pkg::*;
#(
  parameter int MSG_COUNT = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_t             in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_t            out_data,
  input  logic            cfg_wr_en,
  input  logic [CI_W-1:0] cfg_wr_data
);

  localparam int CNT_W = $clog2(MSG_COUNT + 1);
  localparam logic [CI_W-1:0] AVG_DIV = CI_W'(MSG_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_DIV_D,
    S_POST,
    S_DIV_A,
    S_MUL,
    S_FIN,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [CI_W-1:0]   cfg_interval_r;
  in_t               item_r;
  logic              started_r;
  logic [CNT_W-1:0]  msg_count_r;
  logic [DATA_W-1:0] prev_local_r;
  logic [DATA_W-1:0] prev_ref_r;
  logic [DATA_W-1:0] delay_sum_r;
  logic              round_valid_r;
  logic              success_r;
  logic [DATA_W-1:0] adjusted_r;
  logic [DATA_W-1:0] base_r;
  logic [DATA_W-1:0] prod_r;
  logic              timed_out_r;
  logic              done_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [CI_W-1:0]   ci_q;
  logic [CI_W-1:0]   half;
  logic [CI_W:0]     ref_lim;
  logic [DATA_W-1:0] elapsed;
  logic [DATA_W-1:0] tick_el;
  logic [DATA_W-1:0] refd;
  logic              round_up;
  logic [DATA_W-1:0] ev;
  logic [CNT_W-1:0]  cnt_inc;
  logic              last_msg;
  logic              div_start;
  logic [DATA_W-1:0] div_dividend;
  logic [CI_W-1:0]   div_divisor;
  logic              div_done;
  logic [DATA_W-1:0] div_quot;
  logic [CI_W-1:0]   div_rem;
  logic              mul_start;
  logic              mul_done;
  logic [DATA_W-1:0] mul_prod;
  status_t           status_now;
  logic              out_free;

  always_comb begin
    ci_q     = (cfg_interval_r == '0) ? CI_W'(1) : cfg_interval_r;
    half     = ci_q >> 1;
    ref_lim  = {1'b0, ci_q} + {1'b0, half};
    elapsed  = item_r.received_time - prev_local_r;
    tick_el  = item_r.now_time - prev_local_r;
    refd     = item_r.reference_time - prev_ref_r;
    round_up = (div_rem >= half);
    ev       = div_quot + {{(DATA_W-1){1'b0}}, round_up};
    cnt_inc  = msg_count_r + CNT_W'(1);
    last_msg = (cnt_inc == CNT_W'(MSG_COUNT));
    out_free = !out_valid_r || out_ready;

    div_start    = ((state_r == S_DECIDE) && (msg_count_r != '0)) ||
                   ((state_r == S_POST) && last_msg && round_valid_r);
    div_dividend = (state_r == S_POST) ? delay_sum_r :
                   ((item_r.req_type == REQ_MSG) ? elapsed : tick_el);
    div_divisor  = (state_r == S_POST) ? AVG_DIV : ci_q;
    mul_start    = (state_r == S_DIV_A) && div_done && (div_quot != '0);

    if (!started_r) begin
      status_now = ST_NOT_STARTED;
    end else if (msg_count_r == '0) begin
      status_now = success_r ? ST_SUCCEEDED : ST_FAILED;
    end else begin
      status_now = ST_PENDING;
    end
  end

  ldts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  ldts_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (div_quot - DATA_W'(1)),
    .mplier (ci_q),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      cfg_interval_r <= CI_RESET;
      started_r      <= 1'b0;
      msg_count_r    <= '0;
      delay_sum_r    <= '0;
      round_valid_r  <= 1'b1;
      success_r      <= 1'b0;
      adjusted_r     <= '0;
      timed_out_r    <= 1'b0;
      done_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_interval_r <= cfg_wr_data;
      end
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            item_r  <= in_data;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          timed_out_r <= 1'b0;
          done_r      <= 1'b0;
          base_r      <= item_r.now_time - item_r.received_time;
          if (item_r.req_type == REQ_TICK) begin
            state_r <= (msg_count_r == '0) ? S_DONE : S_DIV_D;
          end else begin
            started_r <= 1'b1;
            if (msg_count_r == '0) begin
              delay_sum_r   <= '0;
              round_valid_r <= 1'b1;
              state_r       <= S_POST;
            end else begin
              if ((elapsed < {{(DATA_W-CI_W){1'b0}}, half}) ||
                  (refd >= {{(DATA_W-CI_W-1){1'b0}}, ref_lim})) begin
                round_valid_r <= 1'b0;
              end
              state_r <= S_DIV_D;
            end
          end
        end
        S_DIV_D: begin
          if (div_done) begin
            if (item_r.req_type == REQ_TICK) begin
              if (ev[DATA_W-1:1] != '0) begin
                msg_count_r <= '0;
                success_r   <= 1'b0;
                timed_out_r <= 1'b1;
              end
              state_r <= S_DONE;
            end else begin
              delay_sum_r <= delay_sum_r + ev;
              state_r     <= S_POST;
            end
          end
        end
        S_POST: begin
          prev_local_r <= item_r.received_time;
          prev_ref_r   <= item_r.reference_time;
          base_r       <= base_r + item_r.reference_time;
          if (last_msg) begin
            msg_count_r <= '0;
            success_r   <= round_valid_r;
            done_r      <= 1'b1;
            state_r     <= round_valid_r ? S_DIV_A : S_DONE;
          end else begin
            msg_count_r <= cnt_inc;
            success_r   <= 1'b0;
            state_r     <= S_DONE;
          end
        end
        S_DIV_A: begin
          if (div_done) begin
            if (div_quot == '0) begin
              prod_r  <= '0;
              state_r <= S_FIN;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            prod_r  <= mul_prod + {{(DATA_W-CI_W){1'b0}}, half};
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          adjusted_r <= base_r + prod_r;
          state_r    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_r.train_status  <= status_now;
            out_r.adjusted_time <= adjusted_r;
            out_r.timed_out     <= timed_out_r;
            out_r.round_done    <= done_r;
            out_valid_r         <= 1'b1;
            state_r             <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `LDTS_ASSERT_SAME(a_cnt_range, 1'b1, msg_count_r < CNT_W'(MSG_COUNT), "message count overrun")
  `LDTS_ASSERT_SAME(a_flags_excl, out_valid_r, !(out_r.timed_out && out_r.round_done), "tick and round end together")
  `LDTS_ASSERT_SAME(a_timeout_fail, out_valid_r && out_r.timed_out, out_r.train_status == ST_FAILED, "timeout without failed status")
  `LDTS_ASSERT_SAME(a_done_final, out_valid_r && out_r.round_done, (out_r.train_status == ST_SUCCEEDED) || (out_r.train_status == ST_FAILED), "round end with open status")
  `LDTS_ASSERT_NEXT(a_result_load, (state_r == S_DONE) && out_free, out_valid_r && (state_r == S_IDLE), "finished beat not presented")

endmodule

### dv/tb_link_delay_time_sync_trainer.sv
module tb_link_delay_time_sync_trainer;
  import ldts_pkg::*;

  localparam int ROUND_LEN     = 8;
  localparam int LIMIT_CYCLES  = 1000000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_BEATS   = 100;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_t             in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_t            out_data;
  logic            cfg_wr_en = 1'b0;
  logic [CI_W-1:0] cfg_wr_data = CI_RESET;

  // trainer state as predicted
  logic [31:0] tr_interval = 32'(CI_RESET);
  logic        tr_started = 1'b0;
  int          tr_count = 0;
  logic [31:0] tr_prev_rx = '0;
  logic [31:0] tr_prev_ref = '0;
  logic [31:0] tr_delay_sum = '0;
  logic        tr_round_ok = 1'b1;
  logic        tr_success = 1'b0;
  logic [31:0] tr_adjusted = '0;

  out_t pending_status[$];
  int   mismatch_count = 0;
  int   beats_sent = 0;
  int   results_seen = 0;
  int   cycle_count = 0;
  logic steady = 1'b0;

  link_delay_time_sync_trainer #(.MSG_COUNT(ROUND_LEN)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [31:0] delay_in_events(input logic [31:0] elapsed);
    logic [32:0] d;
    d = {1'b0, elapsed / tr_interval};
    if (elapsed % tr_interval >= tr_interval / 2) d = d + 33'd1;
    return d[31:0];
  endfunction

  function automatic out_t predict_trainer_status(input in_t beat);
    out_t        res;
    logic [31:0] elapsed;
    logic [31:0] ref_delta;
    logic [31:0] avg;
    logic [63:0] adj;
    res.timed_out  = 1'b0;
    res.round_done = 1'b0;
    if (beat.req_type == REQ_TICK) begin
      if (tr_count != 0 && delay_in_events(beat.now_time - tr_prev_rx) > 32'd1) begin
        tr_count       = 0;
        tr_success     = 1'b0;
        res.timed_out  = 1'b1;
      end
    end else begin
      tr_started = 1'b1;
      if (tr_count == 0) begin
        tr_delay_sum = '0;
        tr_round_ok  = 1'b1;
      end else begin
        elapsed      = beat.received_time - tr_prev_rx;
        ref_delta    = beat.reference_time - tr_prev_ref;
        tr_delay_sum = tr_delay_sum + delay_in_events(elapsed);
        if (elapsed < tr_interval / 2) tr_round_ok = 1'b0;
        if (ref_delta >= tr_interval + tr_interval / 2) tr_round_ok = 1'b0;
      end
      tr_prev_rx  = beat.received_time;
      tr_prev_ref = beat.reference_time;
      tr_count++;
      tr_success = 1'b0;
      if (tr_count >= ROUND_LEN) begin
        if (tr_round_ok) begin
          avg = tr_delay_sum / 32'(ROUND_LEN - 1);
          adj = 64'(beat.reference_time);
          if (avg != 0) adj = adj + 64'(avg - 32'd1) * 64'(tr_interval) + 64'(tr_interval / 2);
          adj = adj + 64'(beat.now_time - beat.received_time);
          tr_adjusted = adj[31:0];
        end
        tr_success     = tr_round_ok;
        tr_count       = 0;
        res.round_done = 1'b1;
      end
    end
    if (!tr_started) res.train_status = ST_NOT_STARTED;
    else if (tr_count == 0) res.train_status = tr_success ? ST_SUCCEEDED : ST_FAILED;
    else res.train_status = ST_PENDING;
    res.adjusted_time = tr_adjusted;
    return res;
  endfunction

  // result side: random stall plus compare against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    out_ready <= steady || ($urandom_range(0, 99) >= 33);
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat %0d: %p", results_seen, out_data);
      end else begin
        want = pending_status.pop_front();
        if (out_data.train_status !== want.train_status ||
            out_data.adjusted_time !== want.adjusted_time ||
            out_data.timed_out !== want.timed_out ||
            out_data.round_done !== want.round_done) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch beat %0d: status %0d/%0d adj %h/%h timeout %b/%b done %b/%b",
                     results_seen, want.train_status, out_data.train_status,
                     want.adjusted_time, out_data.adjusted_time,
                     want.timed_out, out_data.timed_out, want.round_done, out_data.round_done);
        end
      end
    end
  end

  task automatic send_beat(input in_t beat);
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    pending_status.push_back(predict_trainer_status(beat));
    beats_sent++;
  endtask

  task automatic send_fields(input logic req, input logic [31:0] now,
                             input logic [31:0] rx, input logic [31:0] rf);
    in_t beat;
    beat.req_type       = req;
    beat.now_time       = now;
    beat.received_time  = rx;
    beat.reference_time = rf;
    send_beat(beat);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_interval(input logic [CI_W-1:0] value);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tr_interval = (value == '0) ? 32'd1 : 32'(value);
  endtask

  // one round of messages with random content, some flawed pairs and some ticks
  task automatic send_round(input int n_msgs, input int flaw_pct, input int tick_pct);
    logic [31:0] rx;
    logic [31:0] rf;
    logic [31:0] now;
    logic [31:0] q;
    int          pick;
    q  = tr_interval;
    rx = $urandom;
    rf = $urandom;
    for (int k = 0; k < n_msgs; k++) begin
      if (k > 0) begin
        if ($urandom_range(0, 99) < tick_pct)
          send_fields(REQ_TICK, rx + $urandom_range(0, 3 * q), $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < flaw_pct / 2) begin
          rx = rx + $urandom_range(0, q / 2);
          rf = rf + $urandom_range(0, q);
        end else if (pick < flaw_pct) begin
          rx = rx + $urandom_range(q / 2, 3 * q);
          rf = rf + q + q / 2 + $urandom_range(0, 2 * q);
        end else if (pick < flaw_pct + 3) begin
          rx = rx + $urandom;
          rf = rf + $urandom;
        end else begin
          rx = rx + $urandom_range(q / 2, 3 * q + q / 2);
          rf = rf + $urandom_range(0, q + q / 2 - 1);
        end
      end
      now = ($urandom_range(0, 9) == 0) ? $urandom : rx + $urandom_range(0, 2 * q);
      send_fields(REQ_MSG, now, rx, rf);
    end
  endtask

  task automatic test_tick_before_start();
    send_fields(REQ_TICK, $urandom, $urandom, $urandom);
  endtask

  // valid round across the 2^32 wrap at the reset interval, rounding boundaries included
  task automatic test_wrapping_round();
    int          steps[7] = '{50, 75, 25, 124, 50, 99, 50};
    int          deltas[7] = '{74, 0, 74, 1, 74, 50, 74};
    logic [31:0] rx;
    logic [31:0] rf;
    rx = 32'hFFFF_FF00;
    rf = 32'hFFFF_FFC0;
    send_fields(REQ_MSG, rx + 32'd3, rx, rf);
    for (int k = 0; k < 7; k++) begin
      rx = rx + steps[k];
      rf = rf + deltas[k];
      send_fields(REQ_MSG, (k == 6) ? rx - 32'd1 : rx, rx, rf);
    end
  endtask

  task automatic test_timeout_tick();
    logic [31:0] rx;
    rx = 32'h0000_1000;
    send_fields(REQ_MSG, rx, rx, 32'd0);
    rx = rx + 60;
    send_fields(REQ_MSG, rx, rx, 32'd60);
    send_fields(REQ_TICK, rx + 74, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_fields(REQ_TICK, rx + 75, 32'd0, 32'd0);
    send_fields(REQ_TICK, rx + 32'h8000_0000, 32'd0, 32'd0);
  endtask

  // interval 0 acts as 1: elapsed of all ones wraps to zero events, average zero
  task automatic test_zero_interval_round();
    logic [31:0] rx;
    write_interval('0);
    rx = 32'd3;
    for (int k = 0; k < ROUND_LEN; k++) begin
      send_fields(REQ_MSG, 32'hFFFF_FFFF, rx, 32'hFFFF_FFFF);
      rx = rx - 32'd1;
    end
  endtask

  task automatic test_random_phases();
    logic [CI_W-1:0] value;
    int              goal;
    int              pick;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: value = 12'd1;
        1: value = 12'd4095;
        2: value = 12'($urandom_range(2, 20));
        3: value = 12'd50;
        4: value = 12'($urandom_range(1, 4000));
        5: value = 12'd0;
        6: value = 12'd4000;
        7: value = 12'($urandom_range(2, 8));
        8: value = 12'($urandom_range(21, 4095));
        default: value = CI_RESET;
      endcase
      write_interval(value);
      steady = (phase == 3);
      goal = beats_sent + PHASE_BEATS;
      while (beats_sent < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) send_round(ROUND_LEN, 8, 8);
        else if (pick < 78) send_round($urandom_range(1, ROUND_LEN - 1), 10, 30);
        else send_fields(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom);
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tick_before_start();
    test_wrapping_round();
    test_timeout_tick();
    test_zero_interval_round();
    test_random_phases();
    settle();
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
